// ----- sv/pmsfp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Particle-sensor frame parser package
// Shared widths, frame constants, status codes and stage-to-stage types.
// ----------------------------------------------------------------------------
package pmsfp_pkg;

   localparam int BYTE_W      = 8;
   localparam int READING_W   = 16;
   localparam int AVG_W       = 20;
   localparam int GROUP_SUM_W = 21;
   localparam int FRAC_BITS   = 4;

   // Default geometry; the top level takes these as parameter defaults.
   localparam int FRAME_BYTES_DEF = 20;
   localparam int AVG_SAMPLES_DEF = 5;

   // Header bytes 16 11 0B, oldest first.
   localparam logic [3*BYTE_W-1:0] HEADER_PATTERN = 24'h16110B;
   localparam logic [BYTE_W-1:0]   HEADER_SUM     = 8'h32;
   localparam int                  HEADER_BYTES   = 3;

   // Frame offsets of the reading bytes.
   localparam int READING_HI_POS = 5;
   localparam int READING_LO_POS = 6;

   // Reciprocal shift: exact floor division for a 25-bit dividend and a
   // divisor up to 32.
   localparam int RECIP_SHIFT = 30;

   typedef enum logic [1:0] {
      STATUS_BAD     = 2'd0,
      STATUS_READING = 2'd1,
      STATUS_AVERAGE = 2'd2
   } status_type;

   typedef struct packed {
      logic                 checksum_ok;
      logic [READING_W-1:0] reading;
   } frame_event_type;

endpackage

// ----- sv/pmsfp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Particle-sensor frame parser channels
// Valid/ready channels for received bytes and frame results.
// ----------------------------------------------------------------------------
interface pmsfp_req_if;
   logic                         valid;
   logic                         ready;
   logic [pmsfp_pkg::BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface pmsfp_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [1:0]                      frame_status;
   logic [pmsfp_pkg::READING_W-1:0] reading;
   logic [pmsfp_pkg::AVG_W-1:0]     average_q4;

   modport source (output valid, output frame_status, output reading, output average_q4,
                   input ready);
   modport sink (input valid, input frame_status, input reading, input average_q4,
                 output ready);
endinterface

// ----- sv/pmsfp_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Particle-sensor frame parser
// Header search, frame capture and checksum; emits one event per frame.
// ----------------------------------------------------------------------------
module pmsfp_parser #(
   parameter int FRAME_BYTES = pmsfp_pkg::FRAME_BYTES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   pmsfp_req_if.sink                    req,
   output logic                         evt_valid,
   output pmsfp_pkg::frame_event_type   evt,
   input  logic                         evt_ready
);

   localparam int POS_W = $clog2(FRAME_BYTES + 1);
   localparam int BW    = pmsfp_pkg::BYTE_W;

   logic [3*BW-1:0]                   window_ff, window_in;
   logic                              capturing_ff, capturing_in;
   logic [POS_W-1:0]                  pos_ff, pos_in, pos_step;
   logic [BW-1:0]                     sum_ff, sum_in, sum_step;
   logic [pmsfp_pkg::READING_W-1:0]   reading_ff, reading_in;
   logic                              evt_valid_ff;
   pmsfp_pkg::frame_event_type        evt_ff;
   logic                              accept, complete;

   assign req.ready = !evt_valid_ff || evt_ready;
   assign accept    = req.valid && req.ready;

   always_comb begin
      window_in    = {window_ff[2*BW-1:0], req.rx_byte};
      reading_in   = reading_ff;
      pos_step     = pos_ff;
      sum_step     = sum_ff;
      if (capturing_ff) begin
         if (pos_ff == POS_W'(pmsfp_pkg::READING_HI_POS)) begin
            reading_in[2*BW-1:BW] = req.rx_byte;
         end else if (pos_ff == POS_W'(pmsfp_pkg::READING_LO_POS)) begin
            reading_in[BW-1:0] = req.rx_byte;
         end
         sum_step = sum_ff + req.rx_byte;
         pos_step = pos_ff + POS_W'(1);
      end
      capturing_in = capturing_ff;
      pos_in       = pos_step;
      sum_in       = sum_step;
      complete     = 1'b0;
      // A header restarts capture, even in mid-frame.
      if (window_in == pmsfp_pkg::HEADER_PATTERN) begin
         capturing_in = 1'b1;
         pos_in       = POS_W'(pmsfp_pkg::HEADER_BYTES);
         sum_in       = pmsfp_pkg::HEADER_SUM;
      end else if (capturing_ff && pos_step >= POS_W'(FRAME_BYTES)) begin
         capturing_in = 1'b0;
         complete     = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= '0;
         capturing_ff <= 1'b0;
         pos_ff       <= '0;
         sum_ff       <= '0;
         reading_ff   <= '0;
         evt_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            window_ff    <= window_in;
            capturing_ff <= capturing_in;
            pos_ff       <= pos_in;
            sum_ff       <= sum_in;
            reading_ff   <= reading_in;
         end
         if (accept && complete) begin
            evt_valid_ff <= 1'b1;
         end else if (evt_ready) begin
            evt_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && complete) begin
         evt_ff.checksum_ok <= (sum_in == '0);
         evt_ff.reading     <= reading_in;
      end
   end

   assign evt_valid = evt_valid_ff;
   assign evt       = evt_ff;

endmodule

// ----- sv/pmsfp_averager.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Particle-sensor reading averager
// Group accumulation, then reciprocal-multiply mean into the result register.
// ----------------------------------------------------------------------------
module pmsfp_averager #(
   parameter int AVG_SAMPLES = pmsfp_pkg::AVG_SAMPLES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         evt_valid,
   input  pmsfp_pkg::frame_event_type   evt,
   output logic                         evt_ready,
   pmsfp_rsp_if.source                  rsp
);

   localparam int CNT_W   = $clog2(AVG_SAMPLES + 1);
   localparam int GSW     = pmsfp_pkg::GROUP_SUM_W;
   localparam int DIVD_W  = GSW + pmsfp_pkg::FRAC_BITS;
   localparam int RS      = pmsfp_pkg::RECIP_SHIFT;
   localparam int PROD_W  = DIVD_W + RS;
   localparam longint unsigned RECIP_VAL =
      ((64'd1 << RS) + 64'(AVG_SAMPLES) - 64'd1) / 64'(AVG_SAMPLES);
   localparam logic [RS-1:0] RECIP = RS'(RECIP_VAL);

   logic [GSW-1:0]                  group_sum_ff, group_sum_in, sum_next;
   logic [CNT_W-1:0]                group_cnt_ff, group_cnt_in, cnt_next;

   // Sum stage
   logic                            d_valid_ff;
   pmsfp_pkg::status_type           d_status_ff, d_status_in;
   logic [pmsfp_pkg::READING_W-1:0] d_reading_ff, d_reading_in;
   logic [GSW-1:0]                  d_sum_ff;
   logic                            d_ready, d_load;

   // Result stage
   logic                            c_valid_ff;
   pmsfp_pkg::status_type           c_status_ff;
   logic [pmsfp_pkg::READING_W-1:0] c_reading_ff;
   logic [pmsfp_pkg::AVG_W-1:0]     c_avg_ff, c_avg_in;
   logic [PROD_W-1:0]               product;
   logic                            c_load;

   assign c_load    = d_valid_ff && (!c_valid_ff || rsp.ready);
   assign d_ready   = !d_valid_ff || c_load;
   assign evt_ready = d_ready;
   assign d_load    = evt_valid && d_ready;

   always_comb begin
      sum_next     = group_sum_ff + GSW'(evt.reading);
      cnt_next     = group_cnt_ff + CNT_W'(1);
      group_sum_in = group_sum_ff;
      group_cnt_in = group_cnt_ff;
      d_status_in  = pmsfp_pkg::STATUS_BAD;
      d_reading_in = '0;
      if (evt.checksum_ok) begin
         d_reading_in = evt.reading;
         if (cnt_next >= CNT_W'(AVG_SAMPLES)) begin
            d_status_in  = pmsfp_pkg::STATUS_AVERAGE;
            group_sum_in = '0;
            group_cnt_in = '0;
         end else begin
            d_status_in  = pmsfp_pkg::STATUS_READING;
            group_sum_in = sum_next;
            group_cnt_in = cnt_next;
         end
      end
   end

   // floor(sum * 16 / AVG_SAMPLES) by reciprocal multiplication.
   assign product = PROD_W'({d_sum_ff, {pmsfp_pkg::FRAC_BITS{1'b0}}}) * PROD_W'(RECIP);

   always_comb begin
      c_avg_in = '0;
      if (d_status_ff == pmsfp_pkg::STATUS_AVERAGE) begin
         c_avg_in = product[RS +: pmsfp_pkg::AVG_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_sum_ff <= '0;
         group_cnt_ff <= '0;
         d_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
      end else begin
         if (d_load) begin
            group_sum_ff <= group_sum_in;
            group_cnt_ff <= group_cnt_in;
            d_valid_ff   <= 1'b1;
         end else if (c_load) begin
            d_valid_ff <= 1'b0;
         end
         if (c_load) begin
            c_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            c_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (d_load) begin
         d_status_ff  <= d_status_in;
         d_reading_ff <= d_reading_in;
         d_sum_ff     <= sum_next;
      end
      if (c_load) begin
         c_status_ff  <= d_status_ff;
         c_reading_ff <= d_reading_ff;
         c_avg_ff     <= c_avg_in;
      end
   end

   assign rsp.valid        = c_valid_ff;
   assign rsp.frame_status = c_status_ff;
   assign rsp.reading      = c_reading_ff;
   assign rsp.average_q4   = c_avg_ff;

endmodule

// ----- sv/pm_sensor_frame_parser_averager.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Particle-sensor frame parser and reading averager
// Finds 16 11 0B framed packets in a byte stream, checks them, averages.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one received sensor byte per word (rx_byte). The block
//   takes a word in every cycle while req_ch.ready is high.
//   rsp_ch carries one word per completed frame: frame_status (bad
//   checksum, reading stored, or reading stored with average ready), the
//   16-bit reading, and the group mean with 4 fraction bits.
//   Bytes outside a frame, and frames cut short by a new header, give no
//   word on rsp_ch.
// Throughput and pipeline:
//   One byte per cycle while rsp_ch.ready stays high. The word for the byte
//   that ends a frame passes through registers on its way to rsp_ch: the
//   event register loads on the accepting edge, then the group-sum register,
//   then the result register behind the mean multiplier.
// Reset:
//   Synchronous. Clears the header window, capture state, group sum and
//   count, and empties every stage.
// Stall:
//   While rsp_ch.ready is low the result word holds; the earlier stages
//   keep filling, and req_ch.ready drops only once a frame event is parked
//   behind them with nowhere to go.
// ----------------------------------------------------------------------------
module pm_sensor_frame_parser_averager #(
   parameter int FRAME_BYTES = pmsfp_pkg::FRAME_BYTES_DEF,
   parameter int AVG_SAMPLES = pmsfp_pkg::AVG_SAMPLES_DEF
) (
   input  logic          clock,
   input  logic          reset,
   pmsfp_req_if.sink     req_ch,
   pmsfp_rsp_if.source   rsp_ch
);

   logic                         evt_valid, evt_ready;
   pmsfp_pkg::frame_event_type   evt;

   // Header search, capture, checksum.
   pmsfp_parser #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .evt_valid (evt_valid),
      .evt       (evt),
      .evt_ready (evt_ready)
   );

   // Group accumulation and mean.
   pmsfp_averager #(
      .AVG_SAMPLES (AVG_SAMPLES)
   ) u_averager (
      .clock     (clock),
      .reset     (reset),
      .evt_valid (evt_valid),
      .evt       (evt),
      .evt_ready (evt_ready),
      .rsp       (rsp_ch)
   );

`ifndef SYNTHESIS
   // Drop the mean unless the word says an average is ready.
   a_avg_only_on_average: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.frame_status != pmsfp_pkg::STATUS_AVERAGE
      |-> rsp_ch.average_q4 == '0)
      else $error("average_q4 nonzero without average status");

   // A bad checksum carries no reading.
   a_bad_has_no_reading: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.frame_status == pmsfp_pkg::STATUS_BAD
      |-> rsp_ch.reading == '0)
      else $error("reading nonzero on bad checksum");

   // Status never takes the unused code.
   a_status_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> rsp_ch.frame_status != 2'd3)
      else $error("illegal frame_status");

   // Advance: the result stage is empty in the cycle after reset is sampled high.
   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("result valid right after reset");
`endif

endmodule

// ----- test/pm_sensor_frame_parser_averager_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Particle-sensor frame parser and averager testbench
// Streams sensor bytes (framed packets, broken packets, line noise) into the
// block with random gaps and a long output stall, predicts every frame
// result in a local parser model and checks each result word field by field.
// ----------------------------------------------------------------------------
module pm_sensor_frame_parser_averager_test;

   import pmsfp_pkg::*;

   localparam int FRAME_LEN    = FRAME_BYTES_DEF;
   localparam int GROUP_LEN    = AVG_SAMPLES_DEF;
   localparam int DRAIN_CYCLES = 24;        // well past the result latency
   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_START   = 600;       // cycle at which the receiver stops taking words
   localparam int HOLD_CYCLES  = 240;

   typedef struct {
      status_type           status;
      logic [READING_W-1:0] reading;
      logic [AVG_W-1:0]     average_q4;
   } frame_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pmsfp_req_if req_ch ();
   pmsfp_rsp_if rsp_ch ();

   pm_sensor_frame_parser_averager i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #1 clock = ~clock;

   // Bytes waiting to be sent, and frame results waiting to arrive.
   logic [BYTE_W-1:0] rx_backlog[$];
   frame_result_type  awaited_results[$];

   int mismatch_cnt = 0;
   int cycle_cnt    = 0;

   // ------------------------------------------------------------------------
   // Frame parser prediction: a private copy of the parser and group state.
   // ------------------------------------------------------------------------
   logic [3*BYTE_W-1:0]    hdr_window  = '0;
   logic                   in_frame    = 1'b0;
   logic [4:0]             frame_pos   = '0;
   logic [BYTE_W-1:0]      byte_sum    = '0;
   logic [READING_W-1:0]   reading_reg = '0;
   logic [GROUP_SUM_W-1:0] group_total = '0;
   logic [3:0]             group_cnt   = '0;

   function void advance_parser(input logic [BYTE_W-1:0] rx);
      frame_result_type outcome;
      logic             done;
      logic [63:0]      scaled;
      done = 1'b0;
      // Add the byte to the frame under capture, keeping the reading bytes.
      if (in_frame) begin
         if (frame_pos == READING_HI_POS) begin
            reading_reg[15:8] = rx;
         end else if (frame_pos == READING_LO_POS) begin
            reading_reg[7:0] = rx;
         end
         byte_sum  = byte_sum + rx;
         frame_pos = frame_pos + 1'b1;
      end
      hdr_window = {hdr_window[2*BYTE_W-1:0], rx};
      // A header wins over frame completion, even on the last frame byte.
      if (hdr_window == HEADER_PATTERN) begin
         in_frame  = 1'b1;
         frame_pos = 5'(HEADER_BYTES);
         byte_sum  = HEADER_SUM;
      end else if (in_frame && frame_pos >= FRAME_LEN) begin
         in_frame = 1'b0;
         done     = 1'b1;
      end
      if (done) begin
         outcome.status     = STATUS_BAD;
         outcome.reading    = '0;
         outcome.average_q4 = '0;
         // Bad checksum: drop the reading, leave the group alone.
         if (byte_sum == '0) begin
            outcome.reading = reading_reg;
            group_total     = group_total + reading_reg;
            group_cnt       = group_cnt + 1'b1;
            if (group_cnt >= GROUP_LEN) begin
               scaled             = (64'(group_total) << FRAC_BITS) / GROUP_LEN;
               outcome.status     = STATUS_AVERAGE;
               outcome.average_q4 = scaled[AVG_W-1:0];
               group_total        = '0;
               group_cnt          = '0;
            end else begin
               outcome.status = STATUS_READING;
            end
         end
         awaited_results.push_back(outcome);
      end
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus builders.
   // ------------------------------------------------------------------------
   // Queue the first 'keep' bytes of a frame carrying 'value'; the last byte
   // zeroes the byte sum unless a bad checksum is wanted.
   task automatic add_frame(input logic [READING_W-1:0] value, input bit bad_sum,
                            input int keep);
      logic [BYTE_W-1:0] frame_bytes [FRAME_LEN];
      logic [BYTE_W-1:0] sum;
      sum = '0;
      for (int i = 0; i < FRAME_LEN - 1; i++) begin
         if (i < HEADER_BYTES) begin
            frame_bytes[i] = HEADER_PATTERN[(HEADER_BYTES-1-i)*BYTE_W +: BYTE_W];
         end else if (i == READING_HI_POS) begin
            frame_bytes[i] = value[15:8];
         end else if (i == READING_LO_POS) begin
            frame_bytes[i] = value[7:0];
         end else begin
            frame_bytes[i] = BYTE_W'($urandom);
         end
         sum = sum + frame_bytes[i];
      end
      frame_bytes[FRAME_LEN-1] = -sum;
      if (bad_sum) begin
         frame_bytes[FRAME_LEN-1] = frame_bytes[FRAME_LEN-1] + BYTE_W'($urandom_range(1, 255));
      end
      for (int i = 0; i < keep; i++) begin
         rx_backlog.push_back(frame_bytes[i]);
      end
   endtask

   task automatic add_noise(input int count);
      for (int i = 0; i < count; i++) begin
         rx_backlog.push_back(BYTE_W'($urandom));
      end
   endtask

   function automatic logic [READING_W-1:0] pick_reading();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) begin
         return '0;
      end else if (roll == 1) begin
         return '1;
      end
      return READING_W'($urandom_range(0, 65535));
   endfunction

   // ------------------------------------------------------------------------
   // Driver: offer backlog bytes, idle for a random send_wait after each accepted
   // word, with bursts of back-to-back words now and then.
   // ------------------------------------------------------------------------
   int send_wait  = 0;
   bit send_burst = 1'b0;
   bit offering;

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid   <= 1'b0;
         req_ch.rx_byte <= '0;
         send_wait = 0;
      end else begin
         offering = req_ch.valid;
         if (req_ch.valid && req_ch.ready) begin
            advance_parser(req_ch.rx_byte);
            offering = 1'b0;
            if ($urandom_range(0, 39) == 0) begin
               send_burst = !send_burst;
            end
            send_wait = send_burst ? 0 : $urandom_range(0, 3);
         end
         // Hold the current word while it is still on offer.
         if (!offering) begin
            if (send_wait != 0) begin
               send_wait--;
               req_ch.valid <= 1'b0;
            end else if (rx_backlog.size() != 0) begin
               req_ch.valid   <= 1'b1;
               req_ch.rx_byte <= rx_backlog.pop_front();
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Long receiver hold-off: stop taking results for a stretch so the block
   // fills up and drops req_ch.ready while bytes keep coming.
   // ------------------------------------------------------------------------
   int hold_clock = 0;
   int hold_left  = 0;

   always @(posedge clock) begin
      if (reset) begin
         hold_clock <= 0;
         hold_left  <= 0;
      end else begin
         hold_clock <= hold_clock + 1;
         if (hold_clock == HOLD_START) begin
            hold_left <= HOLD_CYCLES;
         end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: check each accepted result word against the oldest prediction,
   // then stall for a random take_wait before taking the next one.
   // ------------------------------------------------------------------------
   int               take_wait  = 0;
   bit               take_burst = 1'b0;
   bit               wrong;
   frame_result_type want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         take_wait = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (awaited_results.size() == 0) begin
               wrong = 1'b1;
               want  = '{STATUS_BAD, '0, '0};
            end else begin
               want  = awaited_results.pop_front();
               wrong = (rsp_ch.frame_status !== want.status) ||
                       (rsp_ch.reading !== want.reading) ||
                       (rsp_ch.average_q4 !== want.average_q4);
            end
            if (wrong) begin
               if (mismatch_cnt < 10) begin
                  $display("%0t frame result mismatch%s: got status %0d reading %h avg %h,",
                           $realtime, (awaited_results.size() == 0 && !want.status &&
                           want.reading == '0) ? " (or none expected)" : "",
                           rsp_ch.frame_status, rsp_ch.reading, rsp_ch.average_q4);
                  $display("   expected status %0d reading %h avg %h",
                           want.status, want.reading, want.average_q4);
               end
               mismatch_cnt++;
            end
            if ($urandom_range(0, 19) == 0) begin
               take_burst = !take_burst;
            end
            take_wait = take_burst ? 0 : $urandom_range(0, 3);
         end
         if (take_wait != 0) begin
            take_wait--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= (hold_left == 0);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Run limit.
   // ------------------------------------------------------------------------
   initial begin
      while (cycle_cnt < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_cnt++;
      end
      $display("timeout after %0d cycles, %0d frame results outstanding",
               cycle_cnt, awaited_results.size());
      $display("pm_sensor_frame_parser_averager_test NOT OK");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Stimulus and end of run.
   // ------------------------------------------------------------------------
   int roll;

   initial begin
      req_ch.valid   = 1'b0;
      req_ch.rx_byte = '0;
      rsp_ch.ready   = 1'b0;

      // Directed: line noise with byte extremes and a near-miss header.
      rx_backlog.push_back(8'h00);
      rx_backlog.push_back(8'hFF);
      rx_backlog.push_back(HEADER_PATTERN[23:16]);
      rx_backlog.push_back(HEADER_PATTERN[15:8]);
      rx_backlog.push_back(HEADER_PATTERN[7:0] + 8'h01);
      // Reading extremes, then a bad checksum that must not touch the group.
      add_frame(16'hFFFF, 1'b0, FRAME_LEN);
      add_frame(16'h0000, 1'b0, FRAME_LEN);
      add_frame(16'h1234, 1'b1, FRAME_LEN);
      // New header landing on the last byte of a frame: restart, no result.
      add_frame(16'hA5A5, 1'b0, FRAME_LEN - HEADER_BYTES);
      add_frame(16'hFFFF, 1'b0, FRAME_LEN);
      // Header in the middle of a frame.
      add_frame(16'h5A5A, 1'b0, 8);
      add_frame(16'hFFFF, 1'b0, FRAME_LEN);
      add_frame(16'hFFFF, 1'b0, FRAME_LEN);
      // A full group of maximum readings for the largest average.
      for (int i = 0; i < GROUP_LEN; i++) begin
         add_frame(16'hFFFF, 1'b0, FRAME_LEN);
      end

      // Random: mostly clean frames, some bad, some cut short, some noise.
      while (rx_backlog.size() < 700) begin
         roll = $urandom_range(0, 99);
         if (roll < 65) begin
            add_frame(pick_reading(), 1'b0, FRAME_LEN);
         end else if (roll < 77) begin
            add_frame(pick_reading(), 1'b1, FRAME_LEN);
         end else if (roll < 87) begin
            add_frame(pick_reading(), 1'b0, $urandom_range(HEADER_BYTES, FRAME_LEN - 1));
         end else if (roll < 92) begin
            rx_backlog.push_back(HEADER_PATTERN[23:16]);
            rx_backlog.push_back(HEADER_PATTERN[15:8]);
            add_noise($urandom_range(1, 4));
         end else begin
            add_noise($urandom_range(1, 8));
         end
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Wait for the last byte to go in, then for its results to come out.
      @(negedge clock);
      while (rx_backlog.size() != 0 || req_ch.valid) begin
         @(negedge clock);
      end
      while (awaited_results.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (awaited_results.size() != 0) begin
         $display("%0d frame results never arrived", awaited_results.size());
      end
      if (mismatch_cnt == 0 && awaited_results.size() == 0) begin
         $display("pm_sensor_frame_parser_averager_test OK");
      end else begin
         $display("pm_sensor_frame_parser_averager_test NOT OK");
      end
      $finish;
   end

endmodule
